FILE: hdl/pl0lex_pkg.sv
`default_nettype none

package pl0lex_pkg;

    // default sizes
    localparam int IDENT_MAX_CHARS_DEF   = 11;
    localparam int NUMBER_MAX_DIGITS_DEF = 5;

    // result word shape
    localparam int TOK_W             = 6;
    localparam int NUM_W             = 17;
    localparam int NAME_REPORT_CHARS = 11;
    localparam int MAX_RESULTS       = 3;
    localparam int PUSH_CNT_W        = $clog2(MAX_RESULTS + 1);

    // result queue, power of two
    localparam int QUEUE_DEPTH = 4;

    // keyword lookup view, longest keyword is nine characters
    localparam int KW_VIEW_CHARS = 9;
    localparam int KW_VIEW_BITS  = 8 * KW_VIEW_CHARS;
    localparam int KW_COUNT      = 14;

    typedef logic [TOK_W-1:0] tok_code_t;

    localparam tok_code_t TOK_END       = 6'd0;
    localparam tok_code_t TOK_CONST     = 6'd1;
    localparam tok_code_t TOK_VAR       = 6'd2;
    localparam tok_code_t TOK_PROCEDURE = 6'd3;
    localparam tok_code_t TOK_BEGIN     = 6'd4;
    localparam tok_code_t TOK_KW_END    = 6'd5;
    localparam tok_code_t TOK_WHILE     = 6'd6;
    localparam tok_code_t TOK_DO        = 6'd7;
    localparam tok_code_t TOK_IF        = 6'd8;
    localparam tok_code_t TOK_THEN      = 6'd9;
    localparam tok_code_t TOK_ELSE      = 6'd10;
    localparam tok_code_t TOK_CALL      = 6'd11;
    localparam tok_code_t TOK_WRITE     = 6'd12;
    localparam tok_code_t TOK_READ      = 6'd13;
    localparam tok_code_t TOK_IDENT     = 6'd14;
    localparam tok_code_t TOK_NUMBER    = 6'd15;
    localparam tok_code_t TOK_BECOMES   = 6'd16;
    localparam tok_code_t TOK_PLUS      = 6'd17;
    localparam tok_code_t TOK_MINUS     = 6'd18;
    localparam tok_code_t TOK_TIMES     = 6'd19;
    localparam tok_code_t TOK_SLASH     = 6'd20;
    localparam tok_code_t TOK_PERCENT   = 6'd21;
    localparam tok_code_t TOK_EQL       = 6'd22;
    localparam tok_code_t TOK_NEQ       = 6'd23;
    localparam tok_code_t TOK_LSS       = 6'd24;
    localparam tok_code_t TOK_LEQ       = 6'd25;
    localparam tok_code_t TOK_GTR       = 6'd26;
    localparam tok_code_t TOK_GEQ       = 6'd27;
    localparam tok_code_t TOK_ODD       = 6'd28;
    localparam tok_code_t TOK_LPAREN    = 6'd29;
    localparam tok_code_t TOK_RPAREN    = 6'd30;
    localparam tok_code_t TOK_COMMA     = 6'd31;
    localparam tok_code_t TOK_PERIOD    = 6'd32;
    localparam tok_code_t TOK_SEMICOLON = 6'd33;

    typedef logic [2:0] err_code_t;

    localparam err_code_t ERR_NONE       = 3'd0;
    localparam err_code_t ERR_SYMBOL     = 3'd1;
    localparam err_code_t ERR_IDENT_FORM = 3'd2;
    localparam err_code_t ERR_NUM_LONG   = 3'd3;
    localparam err_code_t ERR_IDENT_LONG = 3'd4;

    // keywords, first character in the top byte, zero padded
    localparam logic [KW_VIEW_BITS-1:0] KW_TEXT [KW_COUNT] = '{
        {"const", 32'h0}, {"var", 48'h0}, {"procedure"}, {"begin", 32'h0},
        {"end", 48'h0}, {"while", 32'h0}, {"do", 56'h0}, {"if", 56'h0},
        {"then", 40'h0}, {"else", 40'h0}, {"call", 40'h0}, {"write", 32'h0},
        {"read", 40'h0}, {"odd", 48'h0}
    };

    localparam tok_code_t KW_CODE [KW_COUNT] = '{
        TOK_CONST, TOK_VAR, TOK_PROCEDURE, TOK_BEGIN, TOK_KW_END, TOK_WHILE,
        TOK_DO, TOK_IF, TOK_THEN, TOK_ELSE, TOK_CALL, TOK_WRITE, TOK_READ, TOK_ODD
    };

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } text_word_t;

    typedef struct packed {
        tok_code_t                          token_type;
        logic [NUM_W-1:0]                   number_value;
        logic [63:0]                        name_chars_low;
        logic [8*(NAME_REPORT_CHARS-8)-1:0] name_chars_high;
        logic [3:0]                         name_length;
        err_code_t                          error_code;
        logic                               last_of_run;
    } tok_word_t;

    // tokens produced by one accepted byte
    typedef struct packed {
        logic [PUSH_CNT_W-1:0]        count;
        tok_word_t [MAX_RESULTS-1:0]  word;
    } push_t;

    typedef struct packed {
        logic      found;
        tok_code_t code;
    } kw_hit_t;

endpackage

`default_nettype wire

FILE: hdl/pl0lex_if.sv
`default_nettype none

// source text channel
interface pl0lex_text_if import pl0lex_pkg::*;;
    logic       valid;
    logic       ready;
    text_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// token channel
interface pl0lex_token_if import pl0lex_pkg::*;;
    logic      valid;
    logic      ready;
    tok_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/pl0lex_kw_match.sv
`default_nettype none

module pl0lex_kw_match import pl0lex_pkg::*;
(
    input  logic                    enable,
    input  logic [KW_VIEW_BITS-1:0] view,
    output kw_hit_t                 hit
);

    // names are zero padded and never contain a zero byte, so a full
    // compare also checks the length
    always_comb
    begin
        hit.found = 1'b0;
        hit.code  = TOK_IDENT;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            if (enable && !hit.found && view == KW_TEXT[k])
            begin
                hit.found = 1'b1;
                hit.code  = KW_CODE[k];
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/pl0lex_scanner.sv
`default_nettype none

module pl0lex_scanner import pl0lex_pkg::*;
#(
    parameter int IDENT_MAX_CHARS   = IDENT_MAX_CHARS_DEF,
    parameter int NUMBER_MAX_DIGITS = NUMBER_MAX_DIGITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  text_word_t text_word,
    output push_t      push
);

    localparam int LEN_MAX   = (IDENT_MAX_CHARS > NUMBER_MAX_DIGITS) ?
                               IDENT_MAX_CHARS : NUMBER_MAX_DIGITS;
    localparam int LEN_W     = $clog2(LEN_MAX + 1);
    localparam int LEN_EXT_W = (LEN_W > 4) ? LEN_W : 4;
    localparam int IDX_W     = (IDENT_MAX_CHARS > 1) ? $clog2(IDENT_MAX_CHARS) : 1;
    localparam int NUM_CAND  = 4;

    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_PERIOD  = 8'h2E;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_Z    = 8'h5A;
    localparam logic [7:0] CH_LO_A    = 8'h61;
    localparam logic [7:0] CH_LO_Z    = 8'h7A;
    localparam logic [7:0] CH_DEL     = 8'h7F;

    typedef enum logic [9:0] {
        MODE_IDLE    = 10'b0000000001,
        MODE_IDENT   = 10'b0000000010,
        MODE_NUMBER  = 10'b0000000100,
        MODE_COLON   = 10'b0000001000,
        MODE_EQ      = 10'b0000010000,
        MODE_BANG    = 10'b0000100000,
        MODE_LT      = 10'b0001000000,
        MODE_GT      = 10'b0010000000,
        MODE_SLASH   = 10'b0100000000,
        MODE_COMMENT = 10'b1000000000
    } scan_mode_t;

    typedef enum logic [1:0] {
        CAND_SYM,
        CAND_IDENT,
        CAND_NUMBER
    } cand_kind_t;

    scan_mode_t           mode_reg, mode_next, mode_upd, idle_mode;
    logic [LEN_W-1:0]     len_reg, len_next, len_upd;
    logic [NUM_W-1:0]     acc_reg, acc_next, acc_upd;
    logic                 halted_reg, halted_next;
    logic [7:0]           ident_buf_reg [IDENT_MAX_CHARS];

    logic [7:0]           c;
    logic                 eot;
    logic                 is_digit, is_alpha, is_space;
    logic [3:0]           digit_val;
    logic                 idle_sym_vld, idle_err;
    tok_code_t            idle_sym;

    logic                 wr_en;
    logic [IDX_W-1:0]     wr_idx;
    logic                 use_idle;
    err_code_t            err;

    logic [NUM_CAND-1:0]  cand_vld;
    cand_kind_t           cand_kind [NUM_CAND];
    tok_code_t            cand_code [NUM_CAND];
    tok_word_t            cand_word [NUM_CAND];

    logic [LEN_EXT_W-1:0] len_ext;
    logic [3:0]           name_len;
    logic [7:0]           name_byte [NAME_REPORT_CHARS];
    logic [KW_VIEW_BITS-1:0] kw_view;
    kw_hit_t              kw_hit;
    tok_word_t            ident_word, number_word;
    logic [PUSH_CNT_W-1:0] n;

    assign c         = text_word.char_code;
    assign eot       = text_word.end_of_text;
    assign is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
    assign is_alpha  = ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LO_A) && (c <= CH_LO_Z));
    assign is_space  = (c <= CH_SPACE) || (c == CH_DEL);
    assign digit_val = 4'(c - CH_ZERO);

    // what a byte does when no token is pending
    always_comb
    begin
        idle_mode    = MODE_IDLE;
        idle_sym_vld = 1'b0;
        idle_sym     = TOK_END;
        idle_err     = 1'b0;
        if (is_space)
        begin
            idle_mode = MODE_IDLE;
        end
        else if (is_digit)
        begin
            idle_mode = MODE_NUMBER;
        end
        else if (is_alpha)
        begin
            idle_mode = MODE_IDENT;
        end
        else
        begin
            unique case (c)
                CH_COLON:   idle_mode = MODE_COLON;
                CH_EQ:      idle_mode = MODE_EQ;
                CH_BANG:    idle_mode = MODE_BANG;
                CH_LT:      idle_mode = MODE_LT;
                CH_GT:      idle_mode = MODE_GT;
                CH_SLASH:   idle_mode = MODE_SLASH;
                CH_PLUS:    begin idle_sym_vld = 1'b1; idle_sym = TOK_PLUS;      end
                CH_MINUS:   begin idle_sym_vld = 1'b1; idle_sym = TOK_MINUS;     end
                CH_STAR:    begin idle_sym_vld = 1'b1; idle_sym = TOK_TIMES;     end
                CH_PERCENT: begin idle_sym_vld = 1'b1; idle_sym = TOK_PERCENT;   end
                CH_LPAREN:  begin idle_sym_vld = 1'b1; idle_sym = TOK_LPAREN;    end
                CH_RPAREN:  begin idle_sym_vld = 1'b1; idle_sym = TOK_RPAREN;    end
                CH_COMMA:   begin idle_sym_vld = 1'b1; idle_sym = TOK_COMMA;     end
                CH_PERIOD:  begin idle_sym_vld = 1'b1; idle_sym = TOK_PERIOD;    end
                CH_SEMI:    begin idle_sym_vld = 1'b1; idle_sym = TOK_SEMICOLON; end
                default:    idle_err = 1'b1;
            endcase
        end
    end

    // candidates in emit order: pending token, new symbol, flush at end, end marker
    always_comb
    begin
        mode_upd = mode_reg;
        len_upd  = len_reg;
        acc_upd  = acc_reg;
        wr_en    = 1'b0;
        wr_idx   = '0;
        use_idle = 1'b0;
        err      = ERR_NONE;
        cand_vld = '0;
        for (int i = 0; i < NUM_CAND; i++)
        begin
            cand_kind[i] = CAND_SYM;
            cand_code[i] = TOK_END;
        end

        unique case (mode_reg)
            MODE_COMMENT:
            begin
                if (c == CH_LF)
                    mode_upd = MODE_IDLE;
            end
            MODE_IDENT:
            begin
                if (is_alpha || is_digit)
                begin
                    if (len_reg >= LEN_W'(IDENT_MAX_CHARS))
                        err = ERR_IDENT_LONG;
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_idx  = len_reg[IDX_W-1:0];
                        len_upd = len_reg + 1'b1;
                    end
                end
                else
                begin
                    cand_vld[0]  = 1'b1;
                    cand_kind[0] = CAND_IDENT;
                    use_idle     = 1'b1;
                end
            end
            MODE_NUMBER:
            begin
                if (is_digit)
                begin
                    if (len_reg >= LEN_W'(NUMBER_MAX_DIGITS))
                        err = ERR_NUM_LONG;
                    else
                    begin
                        acc_upd = (acc_reg << 3) + (acc_reg << 1) + NUM_W'(digit_val);
                        len_upd = len_reg + 1'b1;
                    end
                end
                else if (is_alpha)
                    err = ERR_IDENT_FORM;
                else
                begin
                    cand_vld[0]  = 1'b1;
                    cand_kind[0] = CAND_NUMBER;
                    use_idle     = 1'b1;
                end
            end
            MODE_COLON, MODE_EQ, MODE_BANG:
            begin
                if (c == CH_EQ)
                begin
                    cand_vld[0] = 1'b1;
                    cand_code[0] = (mode_reg == MODE_COLON) ? TOK_BECOMES :
                                   (mode_reg == MODE_EQ)    ? TOK_EQL : TOK_NEQ;
                    mode_upd    = MODE_IDLE;
                end
                else
                    err = ERR_SYMBOL;
            end
            MODE_LT, MODE_GT:
            begin
                cand_vld[0] = 1'b1;
                if (c == CH_EQ)
                begin
                    cand_code[0] = (mode_reg == MODE_LT) ? TOK_LEQ : TOK_GEQ;
                    mode_upd     = MODE_IDLE;
                end
                else
                begin
                    cand_code[0] = (mode_reg == MODE_LT) ? TOK_LSS : TOK_GTR;
                    use_idle     = 1'b1;
                end
            end
            MODE_SLASH:
            begin
                if (c == CH_SLASH)
                    mode_upd = MODE_COMMENT;
                else
                begin
                    cand_vld[0]  = 1'b1;
                    cand_code[0] = TOK_SLASH;
                    use_idle     = 1'b1;
                end
            end
            default:
                use_idle = 1'b1;
        endcase

        if (use_idle)
        begin
            mode_upd     = idle_mode;
            cand_vld[1]  = idle_sym_vld;
            cand_code[1] = idle_sym;
            if (idle_err)
                err = ERR_SYMBOL;
            if (is_digit)
            begin
                acc_upd = NUM_W'(digit_val);
                len_upd = LEN_W'(1);
            end
            if (is_alpha)
            begin
                wr_en   = 1'b1;
                wr_idx  = '0;
                len_upd = LEN_W'(1);
            end
        end

        // end of text flushes what is pending
        if (eot && err == ERR_NONE)
        begin
            unique case (mode_upd)
                MODE_IDENT:  begin cand_vld[2] = 1'b1; cand_kind[2] = CAND_IDENT;  end
                MODE_NUMBER: begin cand_vld[2] = 1'b1; cand_kind[2] = CAND_NUMBER; end
                MODE_LT:     begin cand_vld[2] = 1'b1; cand_code[2] = TOK_LSS;     end
                MODE_GT:     begin cand_vld[2] = 1'b1; cand_code[2] = TOK_GTR;     end
                MODE_SLASH:  begin cand_vld[2] = 1'b1; cand_code[2] = TOK_SLASH;   end
                MODE_COLON, MODE_EQ, MODE_BANG:
                    err = ERR_SYMBOL;
                default:
                    ;
            endcase
            if (err == ERR_NONE)
                cand_vld[3] = 1'b1;
        end
    end

    // identifier view with this byte's write folded in, zero past the length
    assign len_ext = LEN_EXT_W'(len_upd);

    genvar j;
    generate
        for (j = 0; j < NAME_REPORT_CHARS; j++)
        begin : g_view
            if (j < IDENT_MAX_CHARS)
            begin : g_used
                assign name_byte[j] = (LEN_EXT_W'(j) < len_ext) ?
                    ((wr_en && wr_idx == IDX_W'(j)) ? c : ident_buf_reg[j]) : 8'h00;
            end
            else
            begin : g_pad
                assign name_byte[j] = 8'h00;
            end
        end
    endgenerate

    always_comb
    begin
        for (int i = 0; i < KW_VIEW_CHARS; i++)
            kw_view[8*(KW_VIEW_CHARS-1-i) +: 8] = name_byte[i];
    end

    pl0lex_kw_match u_kw_match (
        .enable (len_ext <= LEN_EXT_W'(KW_VIEW_CHARS)),
        .view   (kw_view),
        .hit    (kw_hit)
    );

    assign name_len = (len_ext > LEN_EXT_W'(NAME_REPORT_CHARS)) ?
                      4'(NAME_REPORT_CHARS) : len_ext[3:0];

    always_comb
    begin
        ident_word = '0;
        if (kw_hit.found)
            ident_word.token_type = kw_hit.code;
        else
        begin
            ident_word.token_type = TOK_IDENT;
            for (int i = 0; i < 8; i++)
                ident_word.name_chars_low[8*i +: 8] = name_byte[i];
            for (int i = 8; i < NAME_REPORT_CHARS; i++)
                ident_word.name_chars_high[8*(i-8) +: 8] = name_byte[i];
            ident_word.name_length = name_len;
        end

        number_word              = '0;
        number_word.token_type   = TOK_NUMBER;
        number_word.number_value = acc_upd;

        for (int i = 0; i < NUM_CAND; i++)
        begin
            cand_word[i] = '0;
            unique case (cand_kind[i])
                CAND_IDENT:  cand_word[i] = ident_word;
                CAND_NUMBER: cand_word[i] = number_word;
                default:     cand_word[i].token_type = cand_code[i];
            endcase
        end
    end

    // pack the first three candidates; an error replaces them all
    always_comb
    begin
        push.word = '0;
        n         = '0;
        for (int i = 0; i < NUM_CAND; i++)
        begin
            if (cand_vld[i] && n < PUSH_CNT_W'(MAX_RESULTS))
            begin
                push.word[n] = cand_word[i];
                n            = n + 1'b1;
            end
        end
        if (err != ERR_NONE)
        begin
            push.word               = '0;
            push.word[0].token_type = TOK_END;
            push.word[0].error_code = err;
            n                       = PUSH_CNT_W'(1);
        end
        if (!fire || halted_reg)
            n = '0;
        for (int s = 0; s < MAX_RESULTS; s++)
            push.word[s].last_of_run = (n != '0) && (PUSH_CNT_W'(s) == n - 1'b1);
        push.count = n;
    end

    always_comb
    begin
        mode_next   = mode_reg;
        len_next    = len_reg;
        acc_next    = acc_reg;
        halted_next = halted_reg;
        if (fire && !halted_reg)
        begin
            if (err != ERR_NONE)
            begin
                halted_next = 1'b1;
                mode_next   = MODE_IDLE;
                len_next    = '0;
                acc_next    = '0;
            end
            else if (eot)
            begin
                mode_next = MODE_IDLE;
                len_next  = '0;
                acc_next  = '0;
            end
            else
            begin
                mode_next = mode_upd;
                len_next  = len_upd;
                acc_next  = acc_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            len_reg    <= '0;
            acc_reg    <= '0;
            halted_reg <= 1'b0;
        end
        else
        begin
            mode_reg   <= mode_next;
            len_reg    <= len_next;
            acc_reg    <= acc_next;
            halted_reg <= halted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && !halted_reg && wr_en)
            ident_buf_reg[wr_idx] <= c;
    end

    a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt flag cleared without reset");

    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> push.count == '0)
        else $error("tokens produced while halted");

    a_error_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != '0 && push.word[0].error_code != ERR_NONE)
        |-> (push.count == PUSH_CNT_W'(1)) ##1 halted_reg)
        else $error("error word not alone or not followed by halt");

endmodule

`default_nettype wire

FILE: hdl/pl0lex_res_queue.sv
`default_nettype none

module pl0lex_res_queue import pl0lex_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  push_t      push,
    output logic       room,
    pl0lex_token_if.source token
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    tok_word_t         slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wp_reg, wp_next, rp_reg, rp_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              pop;

    assign token.valid = (cnt_reg != '0);
    assign token.data  = slot_reg[rp_reg];
    assign pop         = token.valid && token.ready;

    // room for a full burst, decided from registers only
    assign room = (cnt_reg <= CNT_W'(QUEUE_DEPTH - MAX_RESULTS));

    always_comb
    begin
        wp_next  = wp_reg + PTR_W'(push.count);
        rp_next  = rp_reg + PTR_W'(pop);
        cnt_next = cnt_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            if (PUSH_CNT_W'(i) < push.count)
                slot_reg[wp_reg + PTR_W'(i)] <= push.word[i];
        end
    end

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("result queue overfilled");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != '0 |-> cnt_reg <= CNT_W'(QUEUE_DEPTH - MAX_RESULTS))
        else $error("burst written without room");

endmodule

`default_nettype wire

FILE: hdl/pl0_lexical_tokenizer.sv
// channel | role   | word                        | handshake
// --------+--------+-----------------------------+------------------
// text    | sink   | char_code, end_of_text      | valid/ready
// token   | source | token_type .. last_of_run   | valid/ready
//
// one source byte per cycle; a byte that closes a token and starts a symbol,
// or ends the text, yields up to three tokens, drained one per cycle
// text.ready drops while more than one token waits in the 4-deep result queue
// rst_n is asynchronous; the identifier buffer itself is not reset
// after an error word the block keeps taking bytes and drops them until reset
// a stall on token never loses a word; text is held off until there is room

`default_nettype none

module pl0_lexical_tokenizer import pl0lex_pkg::*;
#(
    parameter int IDENT_MAX_CHARS   = IDENT_MAX_CHARS_DEF,
    parameter int NUMBER_MAX_DIGITS = NUMBER_MAX_DIGITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    pl0lex_text_if.sink    text,
    pl0lex_token_if.source token
);

    // byte accepted this cycle
    logic  fire;
    // queue can take a full burst of tokens
    logic  room;
    // tokens caused by the current byte
    push_t push;

    assign text.ready = room;
    assign fire       = text.valid && text.ready;

    // scan state, identifier buffer and token assembly
    pl0lex_scanner #(
        .IDENT_MAX_CHARS   (IDENT_MAX_CHARS),
        .NUMBER_MAX_DIGITS (NUMBER_MAX_DIGITS)
    ) u_scanner (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .text_word (text.data),
        .push      (push)
    );

    // result registers, parts the two handshakes
    pl0lex_res_queue u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .room  (room),
        .token (token)
    );

endmodule

`default_nettype wire
